/* sv/bal_pkg.sv */
// Shared types and constants for the bounded list engine.
// No dependencies.
package bal_pkg;
   typedef enum logic [3:0] {
      OP_GET = 4'd0, OP_SET = 4'd1, OP_FRONT = 4'd2, OP_BACK = 4'd3,
      OP_PUSH = 4'd4, OP_POP = 4'd5, OP_INSERT = 4'd6, OP_ERASE = 4'd7,
      OP_FIND = 4'd8, OP_SORT = 4'd9, OP_CLEAR = 4'd10
   } op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_SHUP, S_SHDN, S_FIND,
      S_SORT_I, S_SORT_J, S_SORT_W, S_DONE
   } state_type;
endpackage

/* sv/bal_if.sv */
// Valid/ready channel interfaces for the bounded list engine.
// Depends on nothing; widths follow the work item fields.
interface bal_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         opcode;
   logic [6:0]         position;
   logic signed [31:0] word_in;
   logic               ascending;
   modport source (output valid, opcode, position, word_in, ascending, input ready);
   modport sink   (input valid, opcode, position, word_in, ascending, output ready);
endinterface

interface bal_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] word_out;
   logic [6:0]         found_at;
   logic               found;
   logic [1:0]         status;
   logic [6:0]         count;
   logic               is_empty;
   modport source (output valid, word_out, found_at, found, status, count, is_empty,
                   input ready);
   modport sink   (input valid, word_out, found_at, found, status, count, is_empty,
                   output ready);
endinterface

/* sv/bounded_array_list_engine_unit.sv */
// Bounded list engine: an ordered list of signed 32-bit words in a
// single-port-read memory. Every item runs through a sequencer around that
// memory: insert and erase shift entries one at a time, find scans from the
// front, and sort is an insertion sort. The one memory read port, read then
// write back per entry, sets the pace of each item. The result is held in an
// output register; the next item is taken once it has gone.
module bounded_array_list_engine_unit import bal_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input logic clock,
   input logic reset,
   bal_req_if.sink   req,
   bal_rsp_if.source rsp
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   state_type st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   op_type        op_ff, op_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [31:0]   wd_ff, wd_in;
   logic          up_ff, up_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [31:0]   key_ff, key_in;
   logic          rvalid_ff, rvalid_in;
   logic [31:0]   wout_ff, wout_in;
   logic [6:0]    fat_ff, fat_in;
   logic          fnd_ff, fnd_in;
   logic [1:0]    sts_ff, sts_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;

   bal_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   function automatic logic before_w(logic [31:0] a, logic [31:0] b, logic u);
      logic [31:0] ka, kb;
      ka = a ^ 32'h8000_0000;
      kb = b ^ 32'h8000_0000;
      return u ? (ka < kb) : (ka > kb);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
      op_ff <= op_in; pos_ff <= pos_in; wd_ff <= wd_in; up_ff <= up_in;
      i_ff <= i_in; j_ff <= j_in; key_ff <= key_in; rvalid_ff <= rvalid_in;
      wout_ff <= wout_in; fat_ff <= fat_in; fnd_ff <= fnd_in; sts_ff <= sts_in;
   end

   assign req.ready    = (st_ff == S_IDLE);
   assign rsp.valid    = (st_ff == S_DONE);
   assign rsp.word_out = wout_ff;
   assign rsp.found_at = fat_ff;
   assign rsp.found    = fnd_ff;
   assign rsp.status   = sts_ff;
   assign rsp.count    = 7'(cnt_ff);
   assign rsp.is_empty = (cnt_ff == '0);

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; op_in = op_ff; pos_in = pos_ff;
      wd_in = wd_ff; up_in = up_ff; i_in = i_ff; j_in = j_ff; key_in = key_ff;
      rvalid_in = 1'b0; wout_in = wout_ff; fat_in = fat_ff; fnd_in = fnd_ff;
      sts_in = sts_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = wd_ff; rd_addr = '0;
      case (st_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in  = op_type'(req.opcode);
               pos_in = (CW >= 7) ? CW'(req.position)
                      : ((req.position > 7'(CAP)) ? CAP : CW'(req.position));
               wd_in  = req.word_in;
               up_in  = req.ascending;
               wout_in = '0; fat_in = '0; fnd_in = 1'b0; sts_in = ST_OK;
               st_in  = S_READ;
            end
         end
         S_READ: begin
            // decide and launch the first access
            st_in = S_DONE;
            case (op_ff)
               OP_GET, OP_ERASE: begin
                  if (pos_ff < cnt_ff) begin
                     rd_addr = AW'(pos_ff); rvalid_in = 1'b1; j_in = pos_ff;
                     st_in = (op_ff == OP_ERASE) ? S_SHDN : S_READ;
                     op_in = op_ff;
                     if (op_ff == OP_GET) begin
                        st_in = S_SHDN;
                     end
                  end else sts_in = ST_RANGE;
               end
               OP_SET: begin
                  if (pos_ff < cnt_ff) begin
                     wr_en = 1'b1; wr_addr = AW'(pos_ff);
                  end else sts_in = ST_RANGE;
               end
               OP_FRONT, OP_BACK, OP_POP: begin
                  if (cnt_ff != '0) begin
                     rd_addr = (op_ff == OP_FRONT) ? '0 : AW'(cnt_ff - 1'b1);
                     rvalid_in = 1'b1; j_in = cnt_ff; st_in = S_SHDN;
                  end else sts_in = ST_RANGE;
               end
               OP_PUSH: begin
                  if (cnt_ff >= CAP) sts_in = ST_FULL;
                  else begin
                     wr_en = 1'b1; wr_addr = AW'(cnt_ff); cnt_in = cnt_ff + 1'b1;
                  end
               end
               OP_INSERT: begin
                  if (cnt_ff >= CAP) sts_in = ST_FULL;
                  else if (pos_ff > cnt_ff) sts_in = ST_RANGE;
                  else begin
                     j_in = cnt_ff; st_in = S_SHUP;
                  end
               end
               OP_FIND: begin
                  fat_in = 7'(cnt_ff);
                  if (cnt_ff != '0) begin
                     rd_addr = '0; rvalid_in = 1'b1; j_in = '0; st_in = S_FIND;
                  end
               end
               OP_SORT: begin
                  if (cnt_ff > CW'(1)) begin
                     i_in = CW'(1); st_in = S_SORT_I;
                  end
               end
               OP_CLEAR: cnt_in = '0;
               default: ;
            endcase
         end
         S_SHDN: begin
            // get/front/back/pop capture; erase shifts down one entry at a time, read then write
            if (rvalid_ff) begin
               if (j_ff == pos_ff || op_ff != OP_ERASE) begin
                  wout_in = rd_data;
               end
               if (op_ff != OP_ERASE) begin
                  if (op_ff == OP_POP) cnt_in = cnt_ff - 1'b1;
                  st_in = S_DONE;
               end else if (j_ff != pos_ff) begin
                  wr_en = 1'b1; wr_addr = AW'(j_ff - 1'b1); wr_data = rd_data;
               end
            end else if (j_ff + 1'b1 < cnt_ff) begin
               j_in = j_ff + 1'b1; rd_addr = AW'(j_ff + 1'b1); rvalid_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1; st_in = S_DONE;
            end
         end
         S_SHUP: begin
            if (rvalid_ff) begin
               wr_en = 1'b1; wr_addr = AW'(j_ff); wr_data = rd_data;
               j_in = j_ff - 1'b1;
            end else if (j_ff > pos_ff) begin
               rd_addr = AW'(j_ff - 1'b1); rvalid_in = 1'b1;
            end else begin
               wr_en = 1'b1; wr_addr = AW'(pos_ff); cnt_in = cnt_ff + 1'b1;
               st_in = S_DONE;
            end
         end
         S_FIND: begin
            if (rvalid_ff) begin
               if (rd_data == wd_ff) begin
                  fat_in = 7'(j_ff); fnd_in = 1'b1; st_in = S_DONE;
               end else if (j_ff + 1'b1 < cnt_ff) begin
                  j_in = j_ff + 1'b1;
               end else st_in = S_DONE;
            end else begin
               rd_addr = AW'(j_ff); rvalid_in = 1'b1;
            end
         end
         S_SORT_I: begin
            // fetch key at i
            if (rvalid_ff) begin
               key_in = rd_data; j_in = i_ff; st_in = S_SORT_J;
            end else if (i_ff < cnt_ff) begin
               rd_addr = AW'(i_ff); rvalid_in = 1'b1;
            end else st_in = S_DONE;
         end
         S_SORT_J: begin
            if (rvalid_ff) begin
               if (before_w(key_ff, rd_data, up_ff)) begin
                  wr_en = 1'b1; wr_addr = AW'(j_ff); wr_data = rd_data;
                  j_in = j_ff - 1'b1;
               end else st_in = S_SORT_W;
            end else if (j_ff != '0) begin
               rd_addr = AW'(j_ff - 1'b1); rvalid_in = 1'b1;
            end else st_in = S_SORT_W;
         end
         S_SORT_W: begin
            wr_en = 1'b1; wr_addr = AW'(j_ff); wr_data = key_ff;
            i_in = i_ff + 1'b1; st_in = S_SORT_I;
         end
         S_DONE: begin
            if (rsp.ready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end
endmodule

/* sv/bal_mem.sv */
// Element store: one write port, one read port, registered read data.
// No package dependencies.
module bal_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);
   logic [31:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* sv/bal_checker.sv */
// Port-level checks for the bounded list engine, bound to the top level.
// Depends on bal_pkg and the top level's interfaces.
module bal_checker import bal_pkg::*; (
   input logic clock,
   input logic reset,
   bal_req_if.sink   req,
   bal_rsp_if.source rsp
);
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.is_empty == (rsp.count == 7'd0)))
      else $error("empty flag disagrees with count");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.word_out))
      else $error("result word dropped while stalled");
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.found |-> rsp.found_at < rsp.count)
      else $error("found position beyond count");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("input taken while a result is pending");
endmodule

bind bounded_array_list_engine_unit bal_checker u_bal_checker (
   .clock(clock), .reset(reset), .req(req), .rsp(rsp)
);
